/* rtl/ps2he_pkg.sv */
// ----------------------------------------------------------------------------
// PS/2 host bus engine package
// Shared types, request and event codes, register map and limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ps2he_pkg;

    // Request codes carried by req_type.
    localparam logic [1:0] REQ_SEND = 2'd0;
    localparam logic [1:0] REQ_EDGE = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    // Event codes reported in event_code.
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_SENT    = 3'd1;
    localparam logic [2:0] EV_ACK     = 3'd2;
    localparam logic [2:0] EV_DATA    = 3'd3;
    localparam logic [2:0] EV_SECTION = 3'd4;
    localparam logic [2:0] EV_TIMEOUT = 3'd5;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [1:0] REG_INHIBIT     = 2'd0;
    localparam logic [1:0] REG_DEVICE_WAIT = 2'd1;
    localparam logic [1:0] REG_BIT_GAP     = 2'd2;
    localparam logic [1:0] REG_SECTION_GAP = 2'd3;

    localparam logic [15:0] INHIBIT_RESET     = 16'd100;
    localparam logic [15:0] DEVICE_WAIT_RESET = 16'd15000;
    localparam logic [15:0] BIT_GAP_RESET     = 16'd2000;
    localparam logic [15:0] SECTION_GAP_RESET = 16'd2000;

    localparam logic [7:0] ACK_BYTE    = 8'hFA;
    localparam logic [4:0] MAX_SECTION = 5'd16;

    typedef struct packed {
        logic [15:0] inhibit_time_us;
        logic [15:0] device_wait_us;
        logic [15:0] bit_gap_us;
        logic [15:0] section_gap_us;
    } cfg_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] tx_value;
        logic       data_line;
    } item_t;

    typedef struct packed {
        logic       hold_clock_low;
        logic       hold_data_low;
        logic [2:0] event_code;
        logic [7:0] rx_value;
        logic [4:0] section_bytes;
        logic       busy_res;
    } res_t;

endpackage

`default_nettype wire

/* rtl/ps2he_cfg_regs.sv */
// ----------------------------------------------------------------------------
// PS/2 host bus engine configuration registers
// APB-style register file holding the four timing values in microseconds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ps2he_cfg_regs (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output ps2he_pkg::cfg_t        cfg
);

    ps2he_pkg::cfg_t cfg_reg;
    ps2he_pkg::cfg_t cfg_next;
    logic            wr_en;
    logic [1:0]      reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                ps2he_pkg::REG_INHIBIT:     cfg_next.inhibit_time_us = pwdata[15:0];
                ps2he_pkg::REG_DEVICE_WAIT: cfg_next.device_wait_us  = pwdata[15:0];
                ps2he_pkg::REG_BIT_GAP:     cfg_next.bit_gap_us      = pwdata[15:0];
                ps2he_pkg::REG_SECTION_GAP: cfg_next.section_gap_us  = pwdata[15:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            ps2he_pkg::REG_INHIBIT:     prdata = {16'd0, cfg_reg.inhibit_time_us};
            ps2he_pkg::REG_DEVICE_WAIT: prdata = {16'd0, cfg_reg.device_wait_us};
            ps2he_pkg::REG_BIT_GAP:     prdata = {16'd0, cfg_reg.bit_gap_us};
            ps2he_pkg::REG_SECTION_GAP: prdata = {16'd0, cfg_reg.section_gap_us};
            default:                    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inhibit_time_us <= ps2he_pkg::INHIBIT_RESET;
            cfg_reg.device_wait_us  <= ps2he_pkg::DEVICE_WAIT_RESET;
            cfg_reg.bit_gap_us      <= ps2he_pkg::BIT_GAP_RESET;
            cfg_reg.section_gap_us  <= ps2he_pkg::SECTION_GAP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/ps2he_fsm.sv */
// ----------------------------------------------------------------------------
// PS/2 host bus engine sequencer
// Holds the bus state and applies one item per processing strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ps2he_fsm (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            proc,
    input  ps2he_pkg::item_t     item,
    input  ps2he_pkg::cfg_t      cfg,
    output ps2he_pkg::res_t      res
);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_INHIBIT = 2'd1,
        PH_SEND    = 2'd2,
        PH_RECEIVE = 2'd3
    } phase_t;

    phase_t      phase_reg,    phase_next;
    logic [3:0]  bit_idx_reg,  bit_idx_next;
    logic [7:0]  tx_shift_reg, tx_shift_next;
    logic [7:0]  rx_shift_reg, rx_shift_next;
    logic        parity_reg,   parity_next;
    logic [15:0] timer_reg,    timer_next;
    logic        timer_on_reg, timer_on_next;
    logic [4:0]  tally_reg,    tally_next;
    logic        drv_clk_reg,  drv_clk_next;
    logic        drv_dat_reg,  drv_dat_next;
    logic [2:0]  ev;
    logic [7:0]  rx_out;
    logic [4:0]  count_out;
    logic        tx_bit;

    assign tx_bit = tx_shift_reg[bit_idx_reg[2:0]];

    always_comb
    begin
        phase_next    = phase_reg;
        bit_idx_next  = bit_idx_reg;
        tx_shift_next = tx_shift_reg;
        rx_shift_next = rx_shift_reg;
        parity_next   = parity_reg;
        timer_next    = timer_reg;
        timer_on_next = timer_on_reg;
        tally_next    = tally_reg;
        drv_clk_next  = drv_clk_reg;
        drv_dat_next  = drv_dat_reg;
        ev            = ps2he_pkg::EV_NONE;
        rx_out        = 8'd0;
        count_out     = 5'd0;

        case (item.req_type)
            ps2he_pkg::REQ_SEND:
            begin
                // A send aborts whatever is in progress, section timer included.
                tx_shift_next = item.tx_value;
                drv_clk_next  = 1'b1;
                drv_dat_next  = 1'b0;
                timer_next    = cfg.inhibit_time_us;
                timer_on_next = 1'b1;
                phase_next    = PH_INHIBIT;
            end
            ps2he_pkg::REQ_EDGE:
            begin
                case (phase_reg)
                    PH_SEND:
                    begin
                        timer_next    = cfg.bit_gap_us;
                        timer_on_next = 1'b1;
                        bit_idx_next  = bit_idx_reg + 4'd1;
                        if (bit_idx_reg < 4'd8)
                        begin
                            drv_dat_next = !tx_bit;
                            parity_next  = parity_reg ^ tx_bit;
                        end
                        else if (bit_idx_reg == 4'd8)
                        begin
                            drv_dat_next = !parity_reg;
                        end
                        else if (bit_idx_reg == 4'd9)
                        begin
                            drv_dat_next = 1'b0;
                        end
                        else
                        begin
                            ev            = ps2he_pkg::EV_SENT;
                            phase_next    = PH_IDLE;
                            drv_clk_next  = 1'b0;
                            drv_dat_next  = 1'b0;
                            timer_on_next = 1'b0;
                        end
                    end
                    PH_IDLE:
                    begin
                        // An edge in idle is taken as the start bit of a frame.
                        rx_shift_next = 8'd0;
                        bit_idx_next  = 4'd0;
                        timer_next    = cfg.bit_gap_us;
                        timer_on_next = 1'b1;
                        phase_next    = PH_RECEIVE;
                    end
                    PH_RECEIVE:
                    begin
                        bit_idx_next = bit_idx_reg + 4'd1;
                        if (bit_idx_reg < 4'd8)
                        begin
                            rx_shift_next = {item.data_line, rx_shift_reg[7:1]};
                            timer_next    = cfg.bit_gap_us;
                            timer_on_next = 1'b1;
                        end
                        else if (bit_idx_reg == 4'd8)
                        begin
                            timer_next    = cfg.bit_gap_us;
                            timer_on_next = 1'b1;
                        end
                        else
                        begin
                            rx_out = rx_shift_reg;
                            if (rx_shift_reg == ps2he_pkg::ACK_BYTE)
                            begin
                                ev = ps2he_pkg::EV_ACK;
                            end
                            else
                            begin
                                ev = ps2he_pkg::EV_DATA;
                                if (tally_reg < ps2he_pkg::MAX_SECTION)
                                begin
                                    tally_next = tally_reg + 5'd1;
                                end
                            end
                            timer_next    = cfg.section_gap_us;
                            timer_on_next = 1'b1;
                            phase_next    = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            ps2he_pkg::REQ_TICK:
            begin
                if (timer_on_reg)
                begin
                    if (timer_reg <= 16'd1)
                    begin
                        timer_next    = 16'd0;
                        timer_on_next = 1'b0;
                        case (phase_reg)
                            PH_IDLE:
                            begin
                                ev         = ps2he_pkg::EV_SECTION;
                                count_out  = tally_reg;
                                tally_next = 5'd0;
                            end
                            PH_INHIBIT:
                            begin
                                // Release the clock and drive the start bit.
                                drv_clk_next  = 1'b0;
                                drv_dat_next  = 1'b1;
                                phase_next    = PH_SEND;
                                timer_next    = cfg.device_wait_us;
                                timer_on_next = 1'b1;
                                bit_idx_next  = 4'd0;
                                parity_next   = 1'b1;
                            end
                            default:
                            begin
                                ev           = ps2he_pkg::EV_TIMEOUT;
                                phase_next   = PH_IDLE;
                                drv_clk_next = 1'b0;
                                drv_dat_next = 1'b0;
                            end
                        endcase
                    end
                    else
                    begin
                        timer_next = timer_reg - 16'd1;
                    end
                end
            end
            default:
            begin
                ev = ps2he_pkg::EV_NONE;
            end
        endcase
    end

    always_comb
    begin
        res.hold_clock_low = drv_clk_next;
        res.hold_data_low  = drv_dat_next;
        res.event_code     = ev;
        res.rx_value       = rx_out;
        res.section_bytes  = count_out;
        res.busy_res       = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            bit_idx_reg  <= 4'd0;
            tx_shift_reg <= 8'd0;
            rx_shift_reg <= 8'd0;
            parity_reg   <= 1'b1;
            timer_reg    <= 16'd0;
            timer_on_reg <= 1'b0;
            tally_reg    <= 5'd0;
            drv_clk_reg  <= 1'b0;
            drv_dat_reg  <= 1'b0;
        end
        else if (proc)
        begin
            phase_reg    <= phase_next;
            bit_idx_reg  <= bit_idx_next;
            tx_shift_reg <= tx_shift_next;
            rx_shift_reg <= rx_shift_next;
            parity_reg   <= parity_next;
            timer_reg    <= timer_next;
            timer_on_reg <= timer_on_next;
            tally_reg    <= tally_next;
            drv_clk_reg  <= drv_clk_next;
            drv_dat_reg  <= drv_dat_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/ps2_host_bus_engine.sv */
// ----------------------------------------------------------------------------
// PS/2 host bus engine
// Host side of a PS/2 link: sends bytes, receives frames and reports events.
// ----------------------------------------------------------------------------
// Usage: each input item is a send command, a falling clock edge with the
// sampled data level, or a one-microsecond tick. Items enter on in_valid /
// in_stall and every item produces exactly one result on out_valid /
// out_stall, carrying the line drives, an event code, the received byte,
// the section byte count and a busy flag.
// An item is registered on acceptance and its result is registered when it
// is processed; one item is taken per cycle while no result is stalled.
// The state update is a single pass of logic between the input register
// and the result register.
// When out_stall holds a pending result, the input register keeps its item
// and in_stall rises; no item is lost or reordered. Reset returns the bus to
// idle with both lines released, the timer stopped, the section tally cleared
// and the timing registers at their defaults. The user must write timing
// registers over the APB port while the engine is idle; it is not enforced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ps2_host_bus_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  tx_value,
    input  wire logic        data_line,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             hold_clock_low,
    output logic             hold_data_low,
    output logic [2:0]       event_code,
    output logic [7:0]       rx_value,
    output logic [4:0]       section_bytes,
    output logic             busy_res
);

    ps2he_pkg::cfg_t  cfg;
    ps2he_pkg::item_t item_reg;
    ps2he_pkg::res_t  step_res;
    ps2he_pkg::res_t  res_reg;
    logic             in_vld_reg,  in_vld_next;
    logic             out_vld_reg, out_vld_next;
    logic             out_free;
    logic             proc;

    ps2he_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ps2he_fsm u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .proc  (proc),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (step_res)
    );

    assign out_free = !out_vld_reg || !out_stall;
    assign proc     = in_vld_reg && out_free;
    assign in_stall = in_vld_reg && !out_free;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (!in_stall)
        begin
            in_vld_next = in_valid;
        end
        out_vld_next = out_vld_reg && out_stall;
        if (proc)
        begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.req_type  <= req_type;
            item_reg.tx_value  <= tx_value;
            item_reg.data_line <= data_line;
        end
        if (proc)
        begin
            res_reg <= step_res;
        end
    end

    assign out_valid      = out_vld_reg;
    assign hold_clock_low = res_reg.hold_clock_low;
    assign hold_data_low  = res_reg.hold_data_low;
    assign event_code     = res_reg.event_code;
    assign rx_value       = res_reg.rx_value;
    assign section_bytes  = res_reg.section_bytes;
    assign busy_res       = res_reg.busy_res;

endmodule

`default_nettype wire

/* rtl/ps2he_checker.sv */
// ----------------------------------------------------------------------------
// PS/2 host bus engine checker
// Port-level assertions on result consistency and output handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ps2he_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       hold_clock_low,
    input wire logic       hold_data_low,
    input wire logic [2:0] event_code,
    input wire logic [7:0] rx_value,
    input wire logic [4:0] section_bytes,
    input wire logic       busy_res
);

    // A held result must stay offered until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // Send done and timeout both leave the bus idle with the lines released.
    a_idle_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_code == ps2he_pkg::EV_SENT ||
                      event_code == ps2he_pkg::EV_TIMEOUT)
        |-> !busy_res && !hold_clock_low && !hold_data_low)
        else $error("bus not released at end of transfer");

    // The received byte is only shown with acknowledge and data events.
    a_rx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_code != ps2he_pkg::EV_ACK &&
        event_code != ps2he_pkg::EV_DATA |-> rx_value == 8'd0)
        else $error("received byte outside a receive event");

    // The section count appears only at section end and never exceeds the limit.
    a_section_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> section_bytes <= ps2he_pkg::MAX_SECTION &&
        (event_code == ps2he_pkg::EV_SECTION || section_bytes == 5'd0))
        else $error("section count out of place");

endmodule

bind ps2_host_bus_engine ps2he_checker u_ps2he_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hold_clock_low (hold_clock_low),
    .hold_data_low  (hold_data_low),
    .event_code     (event_code),
    .rx_value       (rx_value),
    .section_bytes  (section_bytes),
    .busy_res       (busy_res)
);

`default_nettype wire
